FILE: hdl/lgt_pkg.sv
// Shared widths, codes and types for the light gate transit timer.
package lgt_pkg;

	localparam int ADC_W          = 12;
	localparam int TIME_W         = 32;
	localparam int PASS_W         = 16;
	localparam int CFG_W          = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FALL_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RISE_THR = CFG_IDX_W'(1);

	localparam logic [ADC_W-1:0] FALL_THR_RST = ADC_W'(1024);
	localparam logic [ADC_W-1:0] RISE_THR_RST = ADC_W'(2048);

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [ADC_W-1:0]  adc_sample;
		logic [TIME_W-1:0] time_us;
	} lgt_item_t;

	typedef struct packed {
		logic              in_zone;
		logic [PASS_W-1:0] pass_count;
		logic [TIME_W-1:0] transit_us;
	} lgt_result_t;

	typedef struct packed {
		logic [ADC_W-1:0] fall;
		logic [ADC_W-1:0] rise;
	} lgt_thr_t;

endpackage

FILE: hdl/lgt_ifs.sv
// Valid/ready channel interfaces for sensor samples and gate results.
interface lgt_sample_if;
	import lgt_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADC_W-1:0]  adc_sample;
	logic [TIME_W-1:0] time_us;

	modport source (output valid, output req_type, output adc_sample, output time_us,
		input ready);
	modport sink (input valid, input req_type, input adc_sample, input time_us,
		output ready);
endinterface

interface lgt_result_if;
	import lgt_pkg::*;

	logic              valid;
	logic              ready;
	logic              in_zone;
	logic [PASS_W-1:0] pass_count;
	logic [TIME_W-1:0] transit_us;

	modport source (output valid, output in_zone, output pass_count, output transit_us,
		input ready);
	modport sink (input valid, input in_zone, input pass_count, input transit_us,
		output ready);
endinterface

FILE: hdl/light_gate_transit_timer.sv
// Light gate transit timer top level: input stage, gate update, result register.
// Accepts one beat per clock while the result side is ready and returns one result beat
// for every accepted beat, through the input and result registers. The rate is set by
// the combinational gate update in stage one (threshold compare, counter increment and
// 32-bit exit-minus-entry subtract); the result register lets a new beat enter while the
// previous result still waits. Thresholds are written through cfg_we, cfg_index (0 fall,
// 1 rise) and cfg_wdata; the user must write only while no beat is in flight (unenforced).
module light_gate_transit_timer #(
	parameter int COUNT_BITS = lgt_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lgt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgt_pkg::CFG_W-1:0]      cfg_wdata,
	lgt_sample_if.sink                     sample_ch,
	lgt_result_if.source                   result_ch
);
	import lgt_pkg::*;

	lgt_thr_t    thr_q;
	logic        valid_s1;
	lgt_item_t   item_s1;
	logic        valid_s2;
	lgt_result_t result_s2;
	lgt_result_t result_n;
	logic        move_s1;
	logic        acc_in;

	assign move_s1         = valid_s1 && (!valid_s2 || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || move_s1;
	assign acc_in          = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.fall <= FALL_THR_RST;
			thr_q.rise <= RISE_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FALL_THR: thr_q.fall <= ADC_W'(cfg_wdata);
				REG_RISE_THR: thr_q.rise <= ADC_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= acc_in || (valid_s1 && !move_s1);
			valid_s2 <= move_s1 || (valid_s2 && !result_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			item_s1.req_type   <= sample_ch.req_type;
			item_s1.adc_sample <= sample_ch.adc_sample;
			item_s1.time_us    <= sample_ch.time_us;
		end
		if (move_s1) begin
			result_s2 <= result_n;
		end
	end

	lgt_gate #(
		.COUNT_BITS(COUNT_BITS)
	) u_gate (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (move_s1),
		.item   (item_s1),
		.thr    (thr_q),
		.result (result_n)
	);

	assign result_ch.valid      = valid_s2;
	assign result_ch.in_zone    = result_s2.in_zone;
	assign result_ch.pass_count = result_s2.pass_count;
	assign result_ch.transit_us = result_s2.transit_us;

endmodule

FILE: hdl/lgt_gate.sv
// Hysteresis gate state, pass counter and transit latch; result of the current beat.
module lgt_gate #(
	parameter int COUNT_BITS = lgt_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lgt_pkg::lgt_item_t  item,
	input  lgt_pkg::lgt_thr_t   thr,
	output lgt_pkg::lgt_result_t result
);
	import lgt_pkg::*;

	logic                  occupied_q;
	logic [TIME_W-1:0]     entry_q;
	logic [TIME_W-1:0]     exit_q;
	logic [TIME_W-1:0]     last_transit_q;
	logic [COUNT_BITS-1:0] passes_q;

	logic                  occupied_n;
	logic [TIME_W-1:0]     entry_n;
	logic [TIME_W-1:0]     exit_n;
	logic [TIME_W-1:0]     transit_n;
	logic [COUNT_BITS-1:0] passes_n;

	always_comb begin
		occupied_n = occupied_q;
		entry_n    = entry_q;
		exit_n     = exit_q;
		passes_n   = passes_q;
		if (item.req_type == REQ_CLEAR) begin
			passes_n = '0;
		end else if (!occupied_q && (item.adc_sample < thr.fall)) begin
			occupied_n = 1'b1;
			entry_n    = item.time_us;
		end else if (occupied_q && (item.adc_sample > thr.rise)) begin
			occupied_n = 1'b0;
			exit_n     = item.time_us;
			passes_n   = passes_q + COUNT_BITS'(1);
		end
		// latch only while the gate is clear; wraps mod 2^32
		transit_n = occupied_n ? last_transit_q : (exit_n - entry_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q     <= 1'b0;
			entry_q        <= '0;
			exit_q         <= '0;
			passes_q       <= '0;
			last_transit_q <= '0;
		end else if (step) begin
			occupied_q     <= occupied_n;
			entry_q        <= entry_n;
			exit_q         <= exit_n;
			passes_q       <= passes_n;
			last_transit_q <= transit_n;
		end
	end

	assign result.in_zone    = occupied_n;
	assign result.pass_count = PASS_W'(passes_n);
	assign result.transit_us = transit_n;

endmodule

FILE: hdl/lgt_checker.sv
// Port-level assertions for the light gate transit timer, bound to the top level.
module lgt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         in_zone,
	input logic [lgt_pkg::PASS_W-1:0]   pass_count,
	input logic [lgt_pkg::TIME_W-1:0]   transit_us
);
	import lgt_pkg::*;

	logic in_acc;
	logic out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// a result appears only after a beat was taken and passed the input register
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 2))
		else $error("result valid rose without an accepted beat two cycles earlier");

	// back-to-back results: count holds, steps by one, or clears
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && $past(out_acc) |->
			(pass_count == $past(pass_count)) ||
			(pass_count == PASS_W'($past(pass_count) + PASS_W'(1))) ||
			(pass_count == '0))
		else $error("pass count jumped between consecutive results");

	// a nonzero increment only happens when an object leaves
	a_count_on_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && $past(out_acc) && (pass_count != '0) &&
		(pass_count == PASS_W'($past(pass_count) + PASS_W'(1))) |->
			!in_zone && $past(in_zone))
		else $error("pass count advanced without an exit");

	// transit stays latched while the gate remains occupied
	a_transit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && $past(out_acc) && in_zone && $past(in_zone) |->
			transit_us == $past(transit_us))
		else $error("transit changed while the gate stayed occupied");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(in_zone) && $stable(pass_count) && $stable(transit_us))
		else $error("stalled result beat changed");

endmodule

bind light_gate_transit_timer lgt_checker u_lgt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_ch.valid),
	.in_ready   (sample_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.in_zone    (result_ch.in_zone),
	.pass_count (result_ch.pass_count),
	.transit_us (result_ch.transit_us)
);
